>>> hw/rtl/omcu_pkg.sv
// ----------------------------------------------------------------------------
// omcu_pkg
// Shared types, codes and defaults for the online mean / covariance block.
// ----------------------------------------------------------------------------
`default_nettype none

package omcu_pkg;

  // Default configuration
  localparam int DIM_DEF        = 4;
  localparam int COUNT_BITS_DEF = 24;

  // Fixed field widths
  localparam int COORD_W = 32;
  localparam int VALUE_W = 64;
  localparam int RC_W    = 2;
  localparam int DIV_W   = 96;

  // Result kind codes
  localparam logic [1:0] KIND_COUNT = 2'd0;
  localparam logic [1:0] KIND_MEAN  = 2'd1;
  localparam logic [1:0] KIND_COV   = 2'd2;

  // Run status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_REM_REFUSED = 2'd1;
  localparam logic [1:0] ST_ADD_REFUSED = 2'd2;

  // Divider dividend select
  localparam logic [1:0] DSEL_MEAN = 2'd0;
  localparam logic [1:0] DSEL_T    = 2'd1;
  localparam logic [1:0] DSEL_C    = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic       take;
    logic       seq_clr_mean;
    logic       seq_clr_count;
    logic       seq_step;
    logic       mprod_ld;
    logic       div_start;
    logic [1:0] div_sel;
    logic       mean_wr;
    logic       opa_ld;
    logic       tprod_ld;
    logic       sum_ld;
    logic       plo_ld;
    logic       phi_ld;
    logic       cov_wr;
    logic       commit;
  } omcu_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic coord_last;
    logic refuse;
    logic div_busy;
    logic seq_last;
    logic out_last;
  } omcu_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/online_mean_covariance_update.sv
// ----------------------------------------------------------------------------
// online_mean_covariance_update
// One cluster's count, mean and covariance, updated one point at a time.
//
//   channel   handshake            payload
//   input     in_valid / in_stall  mode, coordinate
//   output    out_valid/ out_stall kind, row, col, value, status, last
//
// A completing coordinate starts an update on the shared one-bit-per-cycle
// divider (96 steps per quotient, one quotient per mean element, two per
// covariance element), then a run of 1 + DIM + DIM*DIM results, one per
// cycle without stalls. A refused point goes straight to its run. Reset
// (rst, synchronous) clears count, mean and covariance at once. Input is
// stalled during update and run.
// ----------------------------------------------------------------------------
`default_nettype none

module online_mean_covariance_update import omcu_pkg::*; #(
  parameter int DIM        = DIM_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               mode,
  input  wire logic [COORD_W-1:0] coordinate,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              kind,
  output logic [RC_W-1:0]         row,
  output logic [RC_W-1:0]         col,
  output logic [VALUE_W-1:0]      value,
  output logic [1:0]              status,
  output logic                    last
);

  omcu_cmd_t  cmd;
  omcu_stat_t st;

  omcu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  omcu_dp #(
    .DIM        (DIM),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .mode       (mode),
    .coordinate (coordinate),
    .st         (st),
    .kind       (kind),
    .row        (row),
    .col        (col),
    .value      (value),
    .status     (status),
    .last       (last)
  );

endmodule

`default_nettype wire

>>> hw/rtl/omcu_div.sv
// ----------------------------------------------------------------------------
// omcu_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module omcu_div import omcu_pkg::*; #(
  parameter int DVSR_W = COUNT_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DIV_W-1:0]  dividend,
  input  wire logic [DVSR_W-1:0] divisor,
  output logic                   busy,
  output logic [DIV_W-1:0]       quotient
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]  acc;
  logic [DVSR_W-1:0] rem;
  logic [CNT_W-1:0]  cnt;
  logic [DVSR_W:0]   rem2;
  logic [DVSR_W:0]   diff;
  logic              ge;

  // Trial subtract of the shifted partial remainder
  always_comb begin
    rem2 = {rem, acc[DIV_W-1]};
    diff = rem2 - {1'b0, divisor};
    ge   = (rem2 >= {1'b0, divisor});
  end

  // Control: load on start, count down the quotient bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DIV_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath: shift dividend out, quotient bits in
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      rem <= '0;
    end else if (busy) begin
      acc <= {acc[DIV_W-2:0], ge};
      rem <= ge ? diff[DVSR_W-1:0] : rem2[DVSR_W-1:0];
    end
  end

  assign quotient = acc;

endmodule

`default_nettype wire

>>> hw/rtl/omcu_dp.sv
// ----------------------------------------------------------------------------
// omcu_dp
// Datapath: point buffer, count, mean and covariance registers, update math
// and the result sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module omcu_dp import omcu_pkg::*; #(
  parameter int DIM        = DIM_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire omcu_cmd_t          cmd,
  input  wire logic               mode,
  input  wire logic [COORD_W-1:0] coordinate,
  output omcu_stat_t              st,
  output logic [1:0]              kind,
  output logic [RC_W-1:0]         row,
  output logic [RC_W-1:0]         col,
  output logic [VALUE_W-1:0]      value,
  output logic [1:0]              status,
  output logic                    last
);

  localparam int IW = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int CW = (DIM > 1) ? $clog2(DIM * DIM) : 1;
  localparam int PW = COUNT_BITS + 32;
  localparam logic [IW-1:0] I_LAST = IW'(DIM - 1);
  localparam logic [CW-1:0] C_LAST = CW'(DIM * DIM - 1);
  localparam logic [63:0] POS_LIM = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIM = 64'h8000_0000_0000_0000;

  // Signed-magnitude add, magnitude saturates at all ones; returns {sign, mag}
  function automatic logic [64:0] sm_add(input logic na, input logic [63:0] a,
                                         input logic nb, input logic [63:0] b);
    logic [64:0] s;
    logic [64:0] r;
    s = {1'b0, a} + {1'b0, b};
    if (na == nb) begin
      r = {na, s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0]};
    end else if (a >= b) begin
      r = {na, a - b};
    end else begin
      r = {nb, b - a};
    end
    return r;
  endfunction

  // State
  logic [COORD_W-1:0]    pbuf [0:DIM-1];
  logic [IW-1:0]         ccnt;
  logic [COUNT_BITS-1:0] count;
  logic [31:0]           mean [0:DIM-1];
  logic [63:0]           cov  [0:DIM*DIM-1];

  // Update working registers
  logic                  rem_r;
  logic [1:0]            status_r;
  logic [COUNT_BITS-1:0] m_r;
  logic [31:0]           rmag [0:DIM-1];
  logic                  rneg [0:DIM-1];
  logic [1:0]            kind_r;
  logic [IW-1:0]         i_r;
  logic [IW-1:0]         j_r;
  logic [CW-1:0]         c_r;
  logic [63:0]           mprod;
  logic                  sgn_r;
  logic [31:0]           opa_mag;
  logic                  opa_neg;
  logic                  tneg_r;
  logic [63:0]           tprod;
  logic [63:0]           sum_r;
  logic [PW-1:0]         plo;
  logic [PW-1:0]         phi;

  // Combinational terms
  logic                  coord_last;
  logic [1:0]            refuse_code;
  logic [COUNT_BITS-1:0] m_next;
  logic [31:0]           mean_i;
  logic [31:0]           pt_i;
  logic                  mneg;
  logic                  pneg;
  logic [31:0]           mmag;
  logic [31:0]           pmag;
  logic [32:0]           diff33;
  logic [32:0]           dabs;
  logic [PW-1:0]         mprod_w;
  logic [64:0]           mean_sum;
  logic [IW-1:0]         rd_addr;
  logic [31:0]           rd_mag;
  logic                  rd_neg;
  logic [63:0]           cov_c;
  logic                  cneg;
  logic [63:0]           cmag;
  logic [64:0]           cov_sum;
  logic [63:0]           sum_lim;
  logic [PW-1:0]         plo_w;
  logic [PW-1:0]         phi_w;
  logic [DIV_W-1:0]      dividend;
  logic [DIV_W-1:0]      quot;
  logic                  div_busy;
  logic [31:0]           mq;
  logic [31:0]           nmean;
  logic [63:0]           c_lim;
  logic [63:0]           cq;
  logic [63:0]           ncov;
  logic                  i_last;
  logic                  j_last;
  logic                  c_last;

  // Point completion and refusal check
  always_comb begin
    coord_last = (ccnt == I_LAST);
    if (mode) begin
      refuse_code = (count <= COUNT_BITS'(1)) ? ST_REM_REFUSED : ST_OK;
      m_next      = count - COUNT_BITS'(1);
    end else begin
      refuse_code = (count == {COUNT_BITS{1'b1}}) ? ST_ADD_REFUSED : ST_OK;
      m_next      = count + COUNT_BITS'(1);
    end
  end

  // Mean element terms and residual r = mean - point
  always_comb begin
    mean_i   = mean[i_r];
    pt_i     = pbuf[i_r];
    mneg     = mean_i[31];
    pneg     = pt_i[31];
    mmag     = mneg ? (32'd0 - mean_i) : mean_i;
    pmag     = pneg ? (32'd0 - pt_i) : pt_i;
    diff33   = {mean_i[31], mean_i} - {pt_i[31], pt_i};
    dabs     = diff33[32] ? (33'd0 - diff33) : diff33;
    mprod_w  = PW'(count) * PW'(mmag);
    mean_sum = sm_add(mneg, mprod, pneg ^ rem_r, {32'd0, pmag});
  end

  // Residual store read port, row operand then column operand
  always_comb begin
    rd_addr = cmd.opa_ld ? i_r : j_r;
    rd_mag  = rmag[rd_addr];
    rd_neg  = rneg[rd_addr];
  end

  // Covariance sum C +/- T, clamped to the signed range
  always_comb begin
    cov_c   = cov[c_r];
    cneg    = cov_c[63];
    cmag    = cneg ? (64'd0 - cov_c) : cov_c;
    cov_sum = sm_add(cneg, cmag, tneg_r, quot[63:0]);
    sum_lim = cov_sum[64] ? NEG_LIM : POS_LIM;
    plo_w   = PW'(sum_r[31:0]) * PW'(count);
    phi_w   = PW'(sum_r[63:32]) * PW'(count);
  end

  // Dividend select
  always_comb begin
    unique case (cmd.div_sel)
      DSEL_MEAN: dividend = {32'd0, mean_sum[63:0]};
      DSEL_T:    dividend = {32'd0, tprod};
      DSEL_C:    dividend = DIV_W'(plo) + (DIV_W'(phi) << 32);
      default:   dividend = '0;
    endcase
  end

  omcu_div #(
    .DVSR_W (COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (m_r),
    .busy     (div_busy),
    .quotient (quot)
  );

  // Quotient clamps and sign restore
  always_comb begin
    if (sgn_r) begin
      mq = ((|quot[DIV_W-1:32]) || (quot[31:0] > 32'h8000_0000)) ? 32'h8000_0000
                                                                 : quot[31:0];
    end else begin
      mq = ((|quot[DIV_W-1:32]) || quot[31]) ? 32'h7FFF_FFFF : quot[31:0];
    end
    nmean = sgn_r ? (32'd0 - mq) : mq;
    c_lim = sgn_r ? NEG_LIM : POS_LIM;
    cq    = ((|quot[DIV_W-1:64]) || (quot[63:0] > c_lim)) ? c_lim : quot[63:0];
    ncov  = sgn_r ? (64'd0 - cq) : cq;
  end

  // Coordinate intake
  always_ff @(posedge clk) begin
    if (rst) begin
      ccnt     <= '0;
      rem_r    <= 1'b0;
      status_r <= ST_OK;
      m_r      <= '0;
    end else if (cmd.take) begin
      ccnt <= coord_last ? '0 : ccnt + IW'(1);
      if (coord_last) begin
        rem_r    <= mode;
        status_r <= refuse_code;
        m_r      <= m_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pbuf[ccnt] <= coordinate;
    end
  end

  // Count, mean and covariance state
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      for (int k = 0; k < DIM; k++) begin
        mean[k] <= '0;
      end
      for (int k = 0; k < DIM * DIM; k++) begin
        cov[k] <= '0;
      end
    end else begin
      if (cmd.commit) begin
        count <= m_r;
      end
      if (cmd.mean_wr) begin
        mean[i_r] <= nmean;
      end
      if (cmd.cov_wr) begin
        cov[c_r] <= ncov;
      end
    end
  end

  // Update working registers
  always_ff @(posedge clk) begin
    if (cmd.mprod_ld) begin
      mprod      <= 64'(mprod_w);
      rmag[i_r]  <= dabs[31:0];
      rneg[i_r]  <= diff33[32];
    end
    if (cmd.div_start && (cmd.div_sel == DSEL_MEAN)) begin
      sgn_r <= mean_sum[64];
    end else if (cmd.sum_ld) begin
      sgn_r <= cov_sum[64];
    end
    if (cmd.opa_ld) begin
      opa_mag <= rd_mag;
      opa_neg <= rd_neg;
    end
    if (cmd.tprod_ld) begin
      tprod  <= 64'(opa_mag) * 64'(rd_mag);
      tneg_r <= (opa_neg ^ rd_neg) ^ rem_r;
    end
    if (cmd.sum_ld) begin
      sum_r <= (cov_sum[63:0] > sum_lim) ? sum_lim : cov_sum[63:0];
    end
    if (cmd.plo_ld) begin
      plo <= plo_w;
    end
    if (cmd.phi_ld) begin
      phi <= phi_w;
    end
  end

  // Element sequencer shared by update loops and result run
  always_comb begin
    i_last = (i_r == I_LAST);
    j_last = (j_r == I_LAST);
    c_last = (c_r == C_LAST);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kind_r <= KIND_COUNT;
      i_r    <= '0;
      j_r    <= '0;
      c_r    <= '0;
    end else if (cmd.seq_clr_mean || cmd.seq_clr_count) begin
      kind_r <= cmd.seq_clr_mean ? KIND_MEAN : KIND_COUNT;
      i_r    <= '0;
      j_r    <= '0;
      c_r    <= '0;
    end else if (cmd.seq_step) begin
      unique case (kind_r)
        KIND_COUNT: begin
          kind_r <= KIND_MEAN;
          i_r    <= '0;
        end
        KIND_MEAN: begin
          if (i_last) begin
            kind_r <= KIND_COV;
            i_r    <= '0;
            j_r    <= '0;
            c_r    <= '0;
          end else begin
            i_r <= i_r + IW'(1);
          end
        end
        KIND_COV: begin
          c_r <= c_r + CW'(1);
          if (j_last) begin
            j_r <= '0;
            i_r <= i_r + IW'(1);
          end else begin
            j_r <= j_r + IW'(1);
          end
        end
        default: kind_r <= KIND_COUNT;
      endcase
    end
  end

  // Status to controller
  always_comb begin
    st.coord_last = coord_last;
    st.refuse     = (refuse_code != ST_OK);
    st.div_busy   = div_busy;
    st.seq_last   = ((kind_r == KIND_MEAN) && i_last) || ((kind_r == KIND_COV) && c_last);
    st.out_last   = (kind_r == KIND_COV) && c_last;
  end

  // Result fields
  always_comb begin
    kind   = kind_r;
    row    = RC_W'(i_r);
    col    = RC_W'(j_r);
    status = status_r;
    last   = st.out_last;
    unique case (kind_r)
      KIND_COUNT: value = VALUE_W'(count);
      KIND_MEAN:  value = {{16{mean_i[31]}}, mean_i, 16'h0000};
      KIND_COV:   value = cov_c;
      default:    value = '0;
    endcase
  end

  // Coordinate counter stays within the point
  a_ccnt_range: assert property (@(posedge clk) disable iff (rst)
    ccnt <= I_LAST)
    else $error("coordinate counter out of range");

  // Final result of a run is always the last covariance element
  a_last_cov: assert property (@(posedge clk) disable iff (rst)
    last |-> (kind_r == KIND_COV) && (i_r == I_LAST) && (j_r == I_LAST))
    else $error("last flag away from final covariance element");

  // Sequencer holds only the three result kinds
  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    (kind_r == KIND_COUNT) || (kind_r == KIND_MEAN) || (kind_r == KIND_COV))
    else $error("sequencer kind code out of range");

endmodule

`default_nettype wire

>>> hw/rtl/omcu_ctrl.sv
// ----------------------------------------------------------------------------
// omcu_ctrl
// Controller: sequences the mean and covariance updates and the result run.
// ----------------------------------------------------------------------------
`default_nettype none

module omcu_ctrl import omcu_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  input  wire omcu_stat_t st,
  output omcu_cmd_t       cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MPROD  = 4'd1;
  localparam logic [3:0] S_MSTART = 4'd2;
  localparam logic [3:0] S_MWAIT  = 4'd3;
  localparam logic [3:0] S_MWR    = 4'd4;
  localparam logic [3:0] S_TOPA   = 4'd5;
  localparam logic [3:0] S_TPROD  = 4'd6;
  localparam logic [3:0] S_TSTART = 4'd7;
  localparam logic [3:0] S_TWAIT  = 4'd8;
  localparam logic [3:0] S_CSUM   = 4'd9;
  localparam logic [3:0] S_CPLO   = 4'd10;
  localparam logic [3:0] S_CPHI   = 4'd11;
  localparam logic [3:0] S_CSTART = 4'd12;
  localparam logic [3:0] S_CWAIT  = 4'd13;
  localparam logic [3:0] S_CWR    = 4'd14;
  localparam logic [3:0] S_EMIT   = 4'd15;

  logic [3:0] state;
  logic [3:0] state_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_sel = DSEL_MEAN;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (st.coord_last) begin
            if (st.refuse) begin
              cmd.seq_clr_count = 1'b1;
              state_next        = S_EMIT;
            end else begin
              cmd.seq_clr_mean = 1'b1;
              state_next       = S_MPROD;
            end
          end
        end
      end
      S_MPROD: begin
        cmd.mprod_ld = 1'b1;
        state_next   = S_MSTART;
      end
      S_MSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_MEAN;
        state_next    = S_MWAIT;
      end
      S_MWAIT: begin
        if (!st.div_busy) begin
          state_next = S_MWR;
        end
      end
      S_MWR: begin
        cmd.mean_wr  = 1'b1;
        cmd.seq_step = 1'b1;
        state_next   = st.seq_last ? S_TOPA : S_MPROD;
      end
      S_TOPA: begin
        cmd.opa_ld = 1'b1;
        state_next = S_TPROD;
      end
      S_TPROD: begin
        cmd.tprod_ld = 1'b1;
        state_next   = S_TSTART;
      end
      S_TSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_T;
        state_next    = S_TWAIT;
      end
      S_TWAIT: begin
        if (!st.div_busy) begin
          state_next = S_CSUM;
        end
      end
      S_CSUM: begin
        cmd.sum_ld = 1'b1;
        state_next = S_CPLO;
      end
      S_CPLO: begin
        cmd.plo_ld = 1'b1;
        state_next = S_CPHI;
      end
      S_CPHI: begin
        cmd.phi_ld = 1'b1;
        state_next = S_CSTART;
      end
      S_CSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_C;
        state_next    = S_CWAIT;
      end
      S_CWAIT: begin
        if (!st.div_busy) begin
          state_next = S_CWR;
        end
      end
      S_CWR: begin
        cmd.cov_wr = 1'b1;
        if (st.seq_last) begin
          cmd.commit        = 1'b1;
          cmd.seq_clr_count = 1'b1;
          state_next        = S_EMIT;
        end else begin
          cmd.seq_step = 1'b1;
          state_next   = S_TOPA;
        end
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd.seq_step = 1'b1;
          if (st.out_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Divider is quiet whenever requests move
  a_div_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_EMIT) |-> !st.div_busy)
    else $error("divider busy outside update");

  // A divider start is seen as busy on the next cycle
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> st.div_busy)
    else $error("divider did not start");

  // Run ends on the final result
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && st.out_last) |=> (state == S_IDLE))
    else $error("run did not end after final result");

endmodule

`default_nettype wire
